### hdl/pec_pkg.sv
// Package for the page entry update coalescer: word types, config register
// indexes, default parameter values. No dependencies.
`default_nettype none
package pec_pkg;

  // default parameter values
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int FRAME_LSB_DEF   = 12;
  localparam int FRAME_MSB_DEF   = 45;
  localparam int COPY_BITS_DEF   = 16;

  // config port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR_MASK   = 4'd3;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // run modes
  localparam logic [1:0] MODE_DUP_FIRST  = 2'd0;
  localparam logic [1:0] MODE_REPL_FIRST = 2'd1;
  localparam logic [1:0] MODE_DUP_LAST   = 2'd2;
  localparam logic [1:0] MODE_REPL_LAST  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] byte_offset;
    logic [63:0] entry_value;
  } pec_in_t;

  typedef struct packed {
    logic [31:0] start_index;
    logic [1:0]  run_mode;
    logic [15:0] copy_count;
    logic [4:0]  entry_count;
    logic [63:0] entry_out;
    logic        last_entry;
  } pec_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the accepted input word
    logic absorb;     // merge the word into the held request
    logic start_new;  // open a new request with the word
    logic drain_init; // reset the read pointer
    logic drain_run;  // stream held entries out
  } pec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_flush;
    logic empty;
    logic absorb_ok;
    logic drain_done;
  } pec_status_t;

endpackage
`default_nettype wire

### hdl/pec_if.sv
// Valid/ready channel interfaces for the coalescer's input and result words.
// Depends on pec_pkg.
`default_nettype none
interface pec_in_if;
  import pec_pkg::*;
  logic    valid;
  logic    ready;
  pec_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pec_out_if;
  import pec_pkg::*;
  logic     valid;
  logic     ready;
  pec_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/page_entry_update_coalescer.sv
// Page entry update coalescer, top level: controller plus datapath.
// Depends on pec_pkg, pec_if, pec_ctrl, pec_dpath (and pec_ram below it).
//
// Usage:
//  - in_chan carries words {op, byte_offset, entry_value}. op = write merges
//    one page entry into the held request; op = flush emits it.
//  - out_chan carries one word per held entry of an emitted request, in
//    order, with last_entry set on the final word. start_index, run_mode,
//    copy_count and entry_count repeat on every word of a request.
//  - cfg_we/cfg_index/cfg_wdata write table_base (0), entry_limit (1),
//    copy_limit (2) and attr_mask (3). Write only while the block is idle.
//  - Timing: a write that merges or starts a request is accepted, then
//    evaluated against precomputed next-index / next-frame registers.
//    A flush, or a write that cannot merge, drains N held entries through
//    the registered-read entry RAM, and in_chan.ready returns in the cycle
//    after the last word is taken.
//  - in_chan.ready is low while a request drains; one word at a time.
//  - A stalled receiver holds the output word; the RAM read behind it waits.
//  - Reset (synchronous, rst_n low) empties the held request and restores
//    the register defaults; the entry RAM is not cleared (only written
//    slots are ever read).
`default_nettype none
module page_entry_update_coalescer #(
  parameter int MAX_ENTRIES = pec_pkg::MAX_ENTRIES_DEF,
  parameter int FRAME_LSB   = pec_pkg::FRAME_LSB_DEF,
  parameter int FRAME_MSB   = pec_pkg::FRAME_MSB_DEF,
  parameter int COPY_BITS   = pec_pkg::COPY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pec_in_if.sink                              in_chan,
  pec_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [pec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pec_pkg::*;

  pec_cmd_t    cmd;
  pec_status_t st;
  logic        in_ready;
  logic        out_valid;
  pec_out_t    out_data;

  // sequencer: owns the input handshake
  pec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: owns the config, held request, store and output register
  pec_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .FRAME_LSB   (FRAME_LSB),
    .FRAME_MSB   (FRAME_MSB),
    .COPY_BITS   (COPY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_chan.data),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

  // input is taken only when no request is draining
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input accepted while a request drains");

  // every emitted word belongs to a non-empty request
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.data.entry_count != 5'd0))
    else $error("result word with zero entry count");

  // after the final word of a request, the output goes quiet
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.data.last_entry) |=> !out_chan.valid)
    else $error("result word after end of request");

  // the merge path never writes the store during drain (a new request may open as the drain ends)
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_run |-> !cmd.absorb)
    else $error("merge during drain");
endmodule
`default_nettype wire

### hdl/pec_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module pec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hdl/pec_ctrl.sv
// Sequencer for the coalescer: accept, evaluate, drain.
// Depends on pec_pkg.
`default_nettype none
module pec_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pec_pkg::pec_status_t st,
  output pec_pkg::pec_cmd_t         cmd
);
  import pec_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;  // a write waits for the drain to finish

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (st.is_flush) begin
          if (st.empty) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.drain_init = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = ST_DRAIN;
          end
        end else if (st.empty) begin
          cmd.start_new = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (st.absorb_ok) begin
          cmd.absorb = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.drain_init = 1'b1;
          pend_nxt       = 1'b1;
          state_nxt      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.drain_run = 1'b1;
        if (st.drain_done) begin
          cmd.start_new = pend_r;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end
endmodule
`default_nettype wire

### hdl/pec_dpath.sv
// Datapath of the coalescer: config registers, held request, entry store,
// merge checks and the drain pipeline. Depends on pec_pkg and pec_ram.
`default_nettype none
module pec_dpath #(
  parameter int MAX_ENTRIES = pec_pkg::MAX_ENTRIES_DEF,
  parameter int FRAME_LSB   = pec_pkg::FRAME_LSB_DEF,
  parameter int FRAME_MSB   = pec_pkg::FRAME_MSB_DEF,
  parameter int COPY_BITS   = pec_pkg::COPY_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [pec_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pec_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire pec_pkg::pec_in_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output pec_pkg::pec_out_t                         out_data,
  input  wire pec_pkg::pec_cmd_t                    cmd,
  output pec_pkg::pec_status_t                      st
);
  import pec_pkg::*;

  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IDX_SH = FRAME_LSB % 32;
  localparam int FW   = FRAME_MSB - FRAME_LSB + 1;
  localparam logic [63:0] FMASK = (FW <= 0) ? 64'd0 :
                                  (FW >= 64) ? {64{1'b1}} : ((64'd1 << FW) - 64'd1);

  // config
  logic [31:0] table_base_r;
  logic [4:0]  entry_limit_r;
  logic [15:0] copy_limit_r;
  logic [63:0] attr_mask_r;

  // held request
  logic [CNTW-1:0]      count_r;
  logic [COPY_BITS-1:0] copies_r;
  logic [1:0]           mode_r;
  logic [31:0]          start_r;
  logic [63:0]          last_r;      // copy of the newest stored entry
  logic [63:0]          exp_frame_r; // frame a replicate copy must carry
  logic [31:0]          exp_idx_r;   // index the next joining write must have

  // captured word
  logic        op_r;
  logic [63:0] e_r;
  logic [31:0] idx_r;

  // drain
  logic [CNTW-1:0] rd_ptr_r;
  logic            rv_r;       // RAM read data pending
  logic            rlast_r;
  logic            out_valid_r;
  logic [63:0]     out_entry_r;
  logic            out_last_r;
  logic [63:0]     ram_rdata;

  // merge checks
  logic [7:0]  cnt8, lim8;
  logic        first, pos_ok, cap_ok, lim_ok, dup, repl, copy_hit;
  logic        act_copy, act_append;
  logic [1:0]  new_mode;
  logic [63:0] e_frame;
  logic        issue, move;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;

  always_comb begin
    cnt8 = 8'(count_r);
    if (entry_limit_r == 5'd0) begin
      lim8 = 8'd1;
    end else if (8'(entry_limit_r) > 8'(MAX_ENTRIES)) begin
      lim8 = 8'(MAX_ENTRIES);
    end else begin
      lim8 = 8'(entry_limit_r);
    end
    first   = (cnt8 == 8'd1);
    lim_ok  = (cnt8 < lim8);
    pos_ok  = (idx_r == exp_idx_r);
    cap_ok  = (32'(copies_r) != 32'(copy_limit_r));
    e_frame = (e_r >> FRAME_LSB) & FMASK;
    dup     = (e_r == last_r);
    repl    = (((e_r ^ last_r) & attr_mask_r) == 64'd0) && (e_frame == exp_frame_r);

    act_copy   = 1'b0;
    act_append = 1'b0;
    new_mode   = mode_r;
    copy_hit   = (first && mode_r == MODE_DUP_FIRST && dup) ||
                 (first && mode_r == MODE_REPL_FIRST && repl) ||
                 (mode_r == MODE_DUP_LAST && dup) ||
                 (mode_r == MODE_REPL_LAST && repl);
    if (pos_ok && cap_ok) begin
      if (copies_r == '0) begin
        if (dup) begin
          act_copy = 1'b1;
          new_mode = first ? MODE_DUP_FIRST : MODE_DUP_LAST;
        end else if (repl) begin
          act_copy = 1'b1;
          new_mode = first ? MODE_REPL_FIRST : MODE_REPL_LAST;
        end else begin
          act_append = lim_ok;
        end
      end else if (copy_hit) begin
        act_copy = 1'b1;
      end else begin
        act_append = (mode_r == MODE_DUP_FIRST || mode_r == MODE_REPL_FIRST) && lim_ok;
      end
    end
  end

  assign st.is_flush   = (op_r == OP_FLUSH);
  assign st.empty      = (count_r == '0);
  assign st.absorb_ok  = act_copy | act_append;
  assign st.drain_done = out_valid_r && out_ready && out_last_r;

  // drain pipeline: RAM read -> pending data -> output register
  assign move  = rv_r && (!out_valid_r || out_ready);
  assign issue = cmd.drain_run && (rd_ptr_r < count_r) && (!rv_r || move);

  assign ram_we    = cmd.start_new || (cmd.absorb && act_append);
  assign ram_waddr = cmd.start_new ? '0 : count_r[AW-1:0];

  pec_ram #(
    .WIDTH (64),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (e_r),
    .re    (issue),
    .raddr (rd_ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r  <= 32'd0;
      entry_limit_r <= 5'd16;
      copy_limit_r  <= 16'hFFFF;
      attr_mask_r   <= 64'd0;
      count_r       <= '0;
      copies_r      <= '0;
      mode_r        <= MODE_DUP_FIRST;
      start_r       <= 32'd0;
      rd_ptr_r      <= '0;
      rv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_BASE:  table_base_r  <= cfg_wdata[31:0];
          CFG_ENTRY_LIMIT: entry_limit_r <= cfg_wdata[4:0];
          CFG_COPY_LIMIT:  copy_limit_r  <= cfg_wdata[15:0];
          CFG_ATTR_MASK:   attr_mask_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.start_new) begin
        start_r  <= idx_r;
        count_r  <= CNTW'(1);
        copies_r <= '0;
        mode_r   <= MODE_DUP_FIRST;
      end else if (cmd.absorb) begin
        if (act_copy) begin
          copies_r <= copies_r + 1'b1;
          mode_r   <= new_mode;
        end
        if (act_append) begin
          count_r <= count_r + 1'b1;
        end
      end else if (st.drain_done) begin
        count_r <= '0;
      end

      if (cmd.drain_init) begin
        rd_ptr_r <= '0;
      end else if (issue) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end

      if (issue) begin
        rv_r <= 1'b1;
      end else if (move) begin
        rv_r <= 1'b0;
      end

      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.op;
      e_r   <= in_data.entry_value;
      idx_r <= (in_data.byte_offset >> IDX_SH) - (table_base_r >> IDX_SH);
    end
    if (cmd.start_new || (cmd.absorb && act_append)) begin
      last_r <= e_r;
    end
    exp_frame_r <= ((last_r >> FRAME_LSB) & FMASK) + 64'(copies_r) + 64'd1;
    exp_idx_r   <= start_r + 32'(copies_r) + 32'(count_r);
    if (issue) begin
      rlast_r <= (({1'b0, rd_ptr_r} + 1'b1) == {1'b0, count_r});
    end
    if (move) begin
      out_entry_r <= ram_rdata;
      out_last_r  <= rlast_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.start_index = start_r;
  assign out_data.run_mode    = (copies_r != '0) ? mode_r : MODE_DUP_FIRST;
  assign out_data.copy_count  = 16'(32'(copies_r));
  assign out_data.entry_count = cnt8[4:0];
  assign out_data.entry_out   = out_entry_r;
  assign out_data.last_entry  = out_last_r;
endmodule
`default_nettype wire

### tb/tb_page_entry_update_coalescer.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_entry_update_coalescer: random bursty words
// in, stalled receiver out, each result word checked against a local predictor.
// Depends on pec_pkg, pec_if and the coalescer RTL under hdl/.
module tb_page_entry_update_coalescer;
  import pec_pkg::*;

  localparam int NSLOT = MAX_ENTRIES_DEF;
  localparam int FLSB = FRAME_LSB_DEF;
  localparam int FMSB = FRAME_MSB_DEF;
  // entry bits that hold the frame number
  localparam logic [63:0] FRAME_FIELD = ((64'd1 << (FMSB - FLSB + 1)) - 64'd1) << FLSB;

  localparam int PHASES = 7;          // config settings visited
  localparam int RUN_WORDS = 38;      // random words per phase
  localparam int SETTLE = 12;         // idle cycles before a config write
  localparam int QUIET_LIMIT = 1000;  // watchdog: cycles with no handshake at all

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pec_in_if in_chan();
  pec_out_if out_chan();

  page_entry_update_coalescer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and held request, updated per accepted word.
  // ---------------------------------------------------------------------------
  logic [31:0] base_reg = '0;
  logic [4:0] elimit_reg = 5'd16;
  logic [15:0] climit_reg = 16'hFFFF;
  logic [63:0] amask_reg = '0;

  logic [63:0] slot_q [NSLOT];
  int unsigned held_n = 0;
  logic [15:0] run_copies = '0;
  logic [1:0] run_mode_r = MODE_DUP_FIRST;
  logic [31:0] run_start = '0;

  pec_out_t exp_q [$];  // result words still owed by the block

  // effective explicit-entry cap: zero acts as one, large values clamp
  function automatic int unsigned entry_cap();
    if (elimit_reg == 0) return 1;
    if (elimit_reg > NSLOT) return NSLOT;
    return 32'(elimit_reg);
  endfunction

  function automatic logic [63:0] frame_no(logic [63:0] e);
    return (e & FRAME_FIELD) >> FLSB;
  endfunction

  function automatic logic [63:0] with_frame(logic [63:0] e, logic [63:0] f);
    return (e & ~FRAME_FIELD) | ((f << FLSB) & FRAME_FIELD);
  endfunction

  function automatic logic [63:0] tail_entry();
    return slot_q[held_n - 1];
  endfunction

  function automatic bit dup_ok(logic [63:0] e);
    return tail_entry() == e;
  endfunction

  // frame must step by one per copy already counted; masked attrs must match
  function automatic bit repl_ok(logic [63:0] e);
    logic [63:0] b;
    b = tail_entry();
    return ((e & amask_reg) == (b & amask_reg)) &&
           (frame_no(e) == frame_no(b) + 64'(run_copies) + 64'd1);
  endfunction

  // one result word per held entry, last one marked
  function automatic void emit_request();
    pec_out_t r;
    for (int k = 0; k < held_n; k++) begin
      r.start_index = run_start;
      r.run_mode = (run_copies != 0) ? run_mode_r : MODE_DUP_FIRST;
      r.copy_count = run_copies;
      r.entry_count = 5'(held_n);
      r.entry_out = slot_q[k];
      r.last_entry = (k == held_n - 1);
      exp_q.push_back(r);
    end
    held_n = 0;
  endfunction

  function automatic void open_request(logic [31:0] idx, logic [63:0] e);
    run_start = idx;
    slot_q[0] = e;
    held_n = 1;
    run_copies = '0;
    run_mode_r = MODE_DUP_FIRST;
  endfunction

  function automatic void apply_word(pec_in_t w);
    logic [31:0] idx;
    logic [63:0] e;
    bit lone;
    bit merged;
    e = w.entry_value;
    if (w.op == OP_FLUSH) begin
      if (held_n != 0) emit_request();
      return;
    end
    idx = (w.byte_offset >> FLSB) - (base_reg >> FLSB);
    if (held_n == 0) begin
      open_request(idx, e);
      return;
    end
    lone = (held_n == 1);
    merged = 1'b0;
    if (idx - (32'(run_copies) + 32'(held_n)) != run_start || run_copies == climit_reg) begin
      merged = 1'b0;  // not the next page, or copy budget spent
    end else if (run_copies == 0) begin
      // first copy picks the mode; "first" modes only while one entry is held
      if (dup_ok(e)) begin
        run_mode_r = lone ? MODE_DUP_FIRST : MODE_DUP_LAST;
        run_copies++;
        merged = 1'b1;
      end else if (repl_ok(e)) begin
        run_mode_r = lone ? MODE_REPL_FIRST : MODE_REPL_LAST;
        run_copies++;
        merged = 1'b1;
      end else if (held_n < entry_cap()) begin
        slot_q[held_n] = e;
        held_n++;
        merged = 1'b1;
      end
    end else if ((lone && run_mode_r == MODE_DUP_FIRST && dup_ok(e)) ||
                 (lone && run_mode_r == MODE_REPL_FIRST && repl_ok(e)) ||
                 (run_mode_r == MODE_DUP_LAST && dup_ok(e)) ||
                 (run_mode_r == MODE_REPL_LAST && repl_ok(e))) begin
      run_copies++;
      merged = 1'b1;
    end else if (run_mode_r < MODE_DUP_LAST && held_n < entry_cap()) begin
      // copies hang off the first entry, so explicit entries may follow
      slot_q[held_n] = e;
      held_n++;
      merged = 1'b1;
    end
    // a write that cannot join flushes the held request and opens a new one
    if (!merged) begin
      emit_request();
      open_request(idx, e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pending input words, filled by the stimulus block, drained by the driver.
  // hold: sender waits for every owed result word before offering this one.
  // ---------------------------------------------------------------------------
  typedef struct {
    pec_in_t word;
    bit hold;
  } pending_word_t;

  pending_word_t pending_q [$];
  int unsigned words_queued = 0;

  task automatic queue_word(logic op, logic [31:0] offset, logic [63:0] e, bit hold);
    pending_word_t p;
    p.word.op = op;
    p.word.byte_offset = offset;
    p.word.entry_value = e;
    p.hold = hold;
    pending_q.push_back(p);
    words_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps; valid held until accepted.
  // ---------------------------------------------------------------------------
  int unsigned tx_burst = 0;
  int unsigned tx_gap = 0;

  always @(posedge clk) begin
    bit go;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        apply_word(in_chan.data);
        void'(pending_q.pop_front());
      end
      if (!in_chan.valid || in_chan.ready) begin
        go = 1'b0;
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_q.size() != 0) begin
          // a result word taken at this edge still counts as owed, so the
          // check does not hinge on which block runs first
          go = !pending_q[0].hold ||
               (exp_q.size() == 0 && !(out_chan.valid && out_chan.ready));
        end
        if (go) begin
          in_chan.data <= pending_q[0].word;
          if (tx_burst == 0) tx_burst = $urandom_range(1, 16);
          tx_burst--;
          if (tx_burst == 0)
            tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        in_chan.valid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between always ready, coin-flip ready and stall bursts.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode = 0;
  int unsigned rx_timer = 0;
  int unsigned rx_stall = 0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_timer = $urandom_range(20, 120);
      end
      rx_timer--;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom);
        default: begin
          if (rx_stall != 0) begin
            rx_stall--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 10);
          end
        end
      endcase
      out_chan.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each taken result word against the oldest owed word.
  // ---------------------------------------------------------------------------
  int unsigned faults = 0;

  task automatic log_fault(string what, pec_out_t want, pec_out_t got);
    if (faults < 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected start %h mode %0d copies %0d count %0d entry %h last %0d",
               want.start_index, want.run_mode, want.copy_count, want.entry_count,
               want.entry_out, want.last_entry);
      $display("  actual   start %h mode %0d copies %0d count %0d entry %h last %0d",
               got.start_index, got.run_mode, got.copy_count, got.entry_count,
               got.entry_out, got.last_entry);
    end
    faults++;
  endtask

  always @(posedge clk) begin
    pec_out_t want;
    pec_out_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (exp_q.size() == 0) begin
        log_fault("result word with nothing owed", '0, got);
      end else begin
        want = exp_q.pop_front();
        if (got.start_index !== want.start_index || got.run_mode !== want.run_mode ||
            got.copy_count !== want.copy_count || got.entry_count !== want.entry_count ||
            got.entry_out !== want.entry_out || got.last_entry !== want.last_entry)
          log_fault("result word mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no word taken on either side and no config write for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // config writes happen only with the block idle, so the shadow is updated
  // right away
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_TABLE_BASE: base_reg = value[31:0];
      CFG_ENTRY_LIMIT: elimit_reg = value[4:0];
      CFG_COPY_LIMIT: climit_reg = value[15:0];
      CFG_ATTR_MASK: amask_reg = value;
      default: ;
    endcase
  endtask

  // all words taken, nothing owed, then let an absorbing write settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_q.size() != 0 || exp_q.size() != 0 || in_chan.valid);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One well-formed run on consecutive pages: explicit entries, or a copy run
  // (dup or repl) hanging off the first or the last entry, then an ending.
  task automatic gen_run();
    logic [19:0] pg;
    logic [63:0] b;
    logic [63:0] e;
    int unsigned lead;
    int unsigned copies;
    int unsigned tail;
    int unsigned style;
    int unsigned i;
    bit repl;
    bit hold;
    // page counter wraps at 20 bits, so some runs break across the top
    pg = ($urandom_range(0, 7) == 0) ? 20'hFFFFF - 20'($urandom_range(0, 3)) : 20'($urandom);
    hold = ($urandom_range(0, 39) == 0);
    if ($urandom_range(0, 4) == 0)
      queue_word(1'($urandom), $urandom, {$urandom, $urandom}, 1'b0);  // noise
    style = $urandom_range(0, 2);  // 0 explicit only, 1 copies on first, 2 on last
    lead = (style == 1) ? 1 : $urandom_range((style == 2) ? 2 : 1, entry_cap() + 1);
    copies = (style == 0) ? 0 :
             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
    tail = (style == 1) ? $urandom_range(0, 3) : 0;
    repl = 1'($urandom);
    b = '0;
    for (i = 0; i < lead; i++) begin
      b = {$urandom, $urandom};
      queue_word(OP_WRITE, {pg, 12'($urandom)}, b, hold && i == 0);
      pg++;
    end
    for (i = 1; i <= copies; i++) begin
      e = repl ? with_frame(b, frame_no(b) + 64'(i)) : b;
      // bits outside the mask and the frame may differ on a repl copy
      if (repl && $urandom_range(0, 2) == 0)
        e ^= {$urandom, $urandom} & ~amask_reg & ~FRAME_FIELD;
      if ($urandom_range(0, 15) == 0) e = {$urandom, $urandom};  // broken run
      queue_word(OP_WRITE, {pg, 12'($urandom)}, e, 1'b0);
      pg++;
    end
    for (i = 0; i < tail; i++) begin
      queue_word(OP_WRITE, {pg, 12'($urandom)}, {$urandom, $urandom}, 1'b0);
      pg++;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
      5: begin
        // second flush finds nothing held
        queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
        queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
      end
      6: queue_word(OP_WRITE, {pg + 20'd1, 12'($urandom)}, {$urandom, $urandom}, 1'b0);
      default: ;  // next run's first write breaks this one
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] ra;
    logic [63:0] rb;
    logic [31:0] cb;
    logic [4:0] ce;
    logic [15:0] cc;
    logic [63:0] cm;
    int unsigned target;
    int phase;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, reset config (base 0, so page number is the index).
    // flush with nothing held
    queue_word(OP_FLUSH, 32'h0, 64'h0, 1'b0);
    // dup on the first entry, then one more explicit entry
    queue_word(OP_WRITE, {20'd0, 12'($urandom)}, '1, 1'b0);
    queue_word(OP_WRITE, {20'd1, 12'($urandom)}, '1, 1'b0);
    queue_word(OP_WRITE, {20'd2, 12'($urandom)}, '1, 1'b0);
    queue_word(OP_WRITE, {20'd3, 12'($urandom)}, 64'h0, 1'b0);
    queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
    // repl on the first entry: frame steps by one
    ra = with_frame(64'h8000_0000_0000_0ABC, 64'd5);
    queue_word(OP_WRITE, {20'd100, 12'($urandom)}, ra, 1'b0);
    queue_word(OP_WRITE, {20'd101, 12'($urandom)}, with_frame(ra, 64'd6), 1'b0);
    queue_word(OP_WRITE, {20'd102, 12'($urandom)}, with_frame(ra, 64'd7), 1'b0);
    queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
    // dup on the last entry, then a write off the run flushes it
    ra = {$urandom, $urandom};
    rb = {$urandom, $urandom};
    // sender holds off here until the flushed request has fully drained
    queue_word(OP_WRITE, {20'd200, 12'($urandom)}, ra, 1'b1);
    queue_word(OP_WRITE, {20'd201, 12'($urandom)}, rb, 1'b0);
    queue_word(OP_WRITE, {20'd202, 12'($urandom)}, rb, 1'b0);
    queue_word(OP_WRITE, {20'd203, 12'($urandom)}, rb, 1'b0);
    queue_word(OP_WRITE, {20'd300, 12'($urandom)}, ra, 1'b0);
    // repl on the last entry
    rb = with_frame({$urandom, $urandom}, 64'h3_FFFF_FFF0);
    queue_word(OP_WRITE, {20'd301, 12'($urandom)}, rb, 1'b0);
    queue_word(OP_WRITE, {20'd302, 12'($urandom)}, with_frame(rb, 64'h3_FFFF_FFF1), 1'b0);
    queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
    // address extremes: top page then page zero, not consecutive
    queue_word(OP_WRITE, 32'hFFFF_FFFF, 64'h0, 1'b0);
    queue_word(OP_WRITE, 32'h0000_0000, 64'h0, 1'b0);
    queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          // limits at zero: every write after the first flushes
          1: begin cb = 32'hFFFF_FFFF; ce = 5'd0; cc = 16'd0; cm = '1; end
          2: begin cb = $urandom; ce = 5'd31; cc = 16'd1; cm = '0; end
          3: begin cb = 32'h0; ce = 5'd1; cc = 16'hFFFF; cm = {$urandom, $urandom}; end
          4: begin
            cb = $urandom;
            ce = 5'd16;
            cc = 16'($urandom_range(2, 6));
            cm = {$urandom, $urandom} & ~FRAME_FIELD;
          end
          default: begin
            cb = $urandom;
            ce = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
              0: cc = 16'd0;
              1: cc = 16'hFFFF;
              default: cc = 16'($urandom_range(1, 8));
            endcase
            cm = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
          end
        endcase
        write_reg(CFG_TABLE_BASE, 64'(cb));
        write_reg(CFG_ENTRY_LIMIT, 64'(ce));
        write_reg(CFG_COPY_LIMIT, 64'(cc));
        write_reg(CFG_ATTR_MASK, cm);
      end
      target = words_queued + RUN_WORDS;
      while (words_queued < target) gen_run();
      // leave nothing held across a config change
      queue_word(OP_FLUSH, $urandom, {$urandom, $urandom}, 1'b0);
    end

    // all words in, then wait for the owed results plus a margin
    while (pending_q.size() != 0 || exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (exp_q.size() != 0) begin
      $display("%0d result words never arrived", exp_q.size());
      faults += exp_q.size();
    end
    if (faults == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### page_entry_update_coalescer.f
hdl/pec_pkg.sv
hdl/pec_if.sv
hdl/pec_ram.sv
hdl/pec_ctrl.sv
hdl/pec_dpath.sv
hdl/page_entry_update_coalescer.sv
tb/tb_page_entry_update_coalescer.sv
